/* rtl/spo_pkg.sv */
// Package for the suffix/prefix overlap block.
// Holds the controller state type, the per-step flag group and the fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package spo_pkg;

    // Fixed widths of the payload fields.
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 7;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_CALC = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    // Flags that travel with each issued score step.
    typedef struct packed {
        logic valid;      // a step is issued this cycle
        logic first;      // first left symbol: previous column reads as zero
        logic last_pass;  // last left symbol: scores are checked for an overlap
        logic col_one;    // column one: the previous column is the fixed zero entry
    } t_step_flags;

endpackage

/* rtl/suffix_prefix_overlap.sv */
// Top level of the suffix/prefix overlap block: load control, pass sequencer and result register.
// Instantiates spo_char_store and spo_score_unit; depends on spo_pkg.
`timescale 1ns / 1ps

// Usage:
// Character pairs enter on the input channel (valid/ready), one item per cycle
// while a data set loads. The item that carries last_pair ends the set. Pairs past
// MAX_LEN are dropped and the result then reports too_long.
// After the last pair the block runs n passes over the n stored columns, one column
// per cycle through the score memory port, before its single result item appears.
// The input channel is not ready during computation.
// The result sits in an output register; the next set may load while it waits.
// If the receiver stalls with a result still pending, a finished computation holds
// until the output register frees up.
// Reset clears the control state only; the memories need no clearing pass, as the
// first pass of every set treats earlier scores as zero.
module suffix_prefix_overlap #(
    parameter int MAX_LEN = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [spo_pkg::CHAR_W-1:0]  i_suffix_char,
    input  logic [spo_pkg::CHAR_W-1:0]  i_prefix_char,
    input  logic                        i_last_pair,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [spo_pkg::LEN_W-1:0]   o_overlap_len,
    output logic                        o_too_long
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    spo_pkg::t_state r_state;
    logic [CW-1:0]   r_count;
    logic            r_ovf;
    logic [CW-1:0]   r_n;
    logic [AW-1:0]   r_i;
    logic [CW-1:0]   r_j;
    logic            r_too_long;
    logic            r_out_valid;
    logic [spo_pkg::LEN_W-1:0] r_out_len;
    logic            r_out_long;

    logic                 w_accept;
    logic                 w_store;
    logic [CW-1:0]        w_n_set;
    logic [CW-1:0]        w_n_m1;
    logic [CW-1:0]        w_j_m1;
    spo_pkg::t_step_flags w_flags;
    logic [spo_pkg::CHAR_W-1:0] w_left;
    logic [spo_pkg::CHAR_W-1:0] w_right;
    logic [CW-1:0]        w_best;
    logic                 w_busy;
    logic                 w_finish;

    // Load side.
    assign o_in_ready = (r_state == spo_pkg::ST_LOAD);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_store    = (r_count != CW'(MAX_LEN));
    assign w_n_set    = w_store ? (r_count + CW'(1)) : r_count;

    // Step issue: left symbol r_i against column r_j.
    assign w_n_m1 = r_n - CW'(1);
    assign w_j_m1 = r_j - CW'(1);

    always_comb begin
        w_flags           = '0;
        w_flags.valid     = (r_state == spo_pkg::ST_CALC);
        w_flags.first     = (r_i == '0);
        w_flags.last_pass = (CW'(r_i) == w_n_m1);
        w_flags.col_one   = (r_j == CW'(1));
    end

    assign w_finish = (r_state == spo_pkg::ST_FIN) && !w_busy
                      && (!r_out_valid || i_out_ready);

    spo_char_store #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW)
    ) u_chars (
        .i_clk         (i_clk),
        .i_we          (w_accept && w_store),
        .i_waddr       (r_count[AW-1:0]),
        .i_wleft       (i_suffix_char),
        .i_wright      (i_prefix_char),
        .i_raddr_left  (r_i),
        .i_raddr_right (w_j_m1[AW-1:0]),
        .o_left        (w_left),
        .o_right       (w_right)
    );

    spo_score_unit #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .CW      (CW)
    ) u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .i_col   (r_j),
        .i_left  (w_left),
        .i_right (w_right),
        .i_clear (w_accept && i_last_pair),
        .o_best  (w_best),
        .o_busy  (w_busy)
    );

    // Sequencer: load pairs, sweep columns high to low for each left symbol, finish.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spo_pkg::ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                spo_pkg::ST_LOAD: begin
                    if (w_accept) begin
                        if (i_last_pair) begin
                            r_n        <= w_n_set;
                            r_j        <= w_n_set;
                            r_i        <= '0;
                            r_too_long <= r_ovf || !w_store;
                            r_count    <= '0;
                            r_ovf      <= 1'b0;
                            r_state    <= spo_pkg::ST_CALC;
                        end else if (w_store) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                spo_pkg::ST_CALC: begin
                    if (w_flags.col_one) begin
                        r_j <= r_n;
                        if (w_flags.last_pass) begin
                            r_state <= spo_pkg::ST_FIN;
                        end else begin
                            r_i <= r_i + AW'(1);
                        end
                    end else begin
                        r_j <= w_j_m1;
                    end
                end
                spo_pkg::ST_FIN: begin
                    if (w_finish) begin
                        r_state <= spo_pkg::ST_LOAD;
                    end
                end
                default: begin
                    r_state <= spo_pkg::ST_LOAD;
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_len  <= spo_pkg::LEN_W'(w_best);
            r_out_long <= r_too_long;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_overlap_len = r_out_len;
    assign o_too_long    = r_out_long;

endmodule

/* rtl/spo_char_store.sv */
// Character stores for the left and right strings of the suffix/prefix overlap block.
// Two synchronous memories, one write and one registered read each.
// Depends on spo_pkg.
`timescale 1ns / 1ps

module spo_char_store #(
    parameter int MAX_LEN = 64,
    parameter int AW      = 6
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [spo_pkg::CHAR_W-1:0] i_wleft,
    input  logic [spo_pkg::CHAR_W-1:0] i_wright,
    input  logic [AW-1:0]              i_raddr_left,
    input  logic [AW-1:0]              i_raddr_right,
    output logic [spo_pkg::CHAR_W-1:0] o_left,
    output logic [spo_pkg::CHAR_W-1:0] o_right
);

    logic [spo_pkg::CHAR_W-1:0] r_left_mem  [MAX_LEN];
    logic [spo_pkg::CHAR_W-1:0] r_right_mem [MAX_LEN];
    logic [spo_pkg::CHAR_W-1:0] r_left_q;
    logic [spo_pkg::CHAR_W-1:0] r_right_q;

    // Pair writes during loading.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_left_mem[i_waddr]  <= i_wleft;
            r_right_mem[i_waddr] <= i_wright;
        end
    end

    // Registered reads during the score passes.
    always_ff @(posedge i_clk) begin
        r_left_q  <= r_left_mem[i_raddr_left];
        r_right_q <= r_right_mem[i_raddr_right];
    end

    assign o_left  = r_left_q;
    assign o_right = r_right_q;

endmodule

/* rtl/spo_score_unit.sv */
// Score store and recurrence step of the suffix/prefix overlap block.
// Reads the previous column, updates the current one and tracks the best overlap.
// Depends on spo_pkg.
`timescale 1ns / 1ps

module spo_score_unit #(
    parameter int MAX_LEN = 64,
    parameter int AW      = 6,
    parameter int CW      = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  spo_pkg::t_step_flags       i_flags,
    input  logic [CW-1:0]              i_col,
    input  logic [spo_pkg::CHAR_W-1:0] i_left,
    input  logic [spo_pkg::CHAR_W-1:0] i_right,
    input  logic                       i_clear,
    output logic [CW-1:0]              o_best,
    output logic                       o_busy
);

    // Entry k holds the score of column k+1; column zero is always zero.
    logic [CW-1:0]        r_mem [MAX_LEN];
    logic [CW-1:0]        r_rd_data;
    spo_pkg::t_step_flags r_flags;
    logic [CW-1:0]        r_col;
    logic                 r_byp_hit;
    logic [CW-1:0]        r_byp_data;
    logic [CW-1:0]        r_best;

    logic [CW-1:0] w_col_m2;
    logic [CW-1:0] w_col_m1;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    logic          w_we;
    logic [CW-1:0] w_prev;
    logic [CW-1:0] w_new;
    logic          w_hit;

    // Issue side: read the previous column of the stepped column.
    assign w_col_m2  = i_col - CW'(2);
    assign w_rd_addr = w_col_m2[AW-1:0];

    // Update side: write the current column in the cycle after its read is issued.
    assign w_col_m1  = r_col - CW'(1);
    assign w_wr_addr = w_col_m1[AW-1:0];
    assign w_we      = r_flags.valid;

    // A read of the entry being written this cycle takes the new value.
    assign w_hit = w_we && (w_wr_addr == w_rd_addr);

    always_comb begin
        if (r_flags.first || r_flags.col_one) begin
            w_prev = '0;
        end else if (r_byp_hit) begin
            w_prev = r_byp_data;
        end else begin
            w_prev = r_rd_data;
        end
        if (i_left == i_right) begin
            w_new = w_prev + CW'(1);
        end else begin
            w_new = '0;
        end
    end

    // Score memory.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_new;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Step pipeline register and forwarding capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= i_flags;
        end
        r_col      <= i_col;
        r_byp_hit  <= w_hit;
        r_byp_data <= w_new;
    end

    // On the last pass a column whose score equals its index is a full overlap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_best <= '0;
        end else if (r_flags.valid && r_flags.last_pass && (w_new == r_col)
                     && (w_new > r_best)) begin
            r_best <= w_new;
        end
    end

    assign o_best = r_best;
    assign o_busy = r_flags.valid;

endmodule
